// ===== rtl/core/rkke_pkg.sv =====
// Package for the rolling k-mer key extractor.
// Holds widths, the base encoding and the window length clamp; no dependencies.
`timescale 1ns / 1ps

package rkke_pkg;

  localparam int MAX_K      = 32;
  localparam int KEY_W      = 2 * MAX_K;
  localparam int K_W        = 6;
  localparam int RUN_W      = 6;
  localparam int IDX_W      = 33;
  localparam int POS_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int CODE_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [K_W-1:0]    K_RESET     = K_W'(21);
  localparam logic [K_W-1:0]    K_MAX       = K_W'(MAX_K);
  localparam logic [RUN_W-1:0]  RUN_MAX     = '1;
  localparam logic [ADDR_W-1:0] ADDR_KMER_LEN = ADDR_W'(0);

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] window_start;
  } ctrl_res_t;

  // A/C/G/T in either case map to 0..3; anything else is an N and shifts in 3.
  function automatic logic [CODE_W:0] encode_base(input logic [CHAR_W-1:0] c);
    logic [CODE_W:0] r;
    begin
      case (c)
        "A", "a": r = {1'b1, 2'd0};
        "C", "c": r = {1'b1, 2'd1};
        "G", "g": r = {1'b1, 2'd2};
        "T", "t": r = {1'b1, 2'd3};
        default:  r = {1'b0, 2'd3};
      endcase
      return r;
    end
  endfunction

  function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] k);
    logic [K_W-1:0] r;
    begin
      r = k;
      if (k == '0) begin
        r = K_W'(1);
      end else if (k > K_MAX) begin
        r = K_MAX;
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/rkke_cell.sv =====
// One cell of the key shift chain: holds one 2-bit base code.
// Depends on rkke_pkg.
`timescale 1ns / 1ps

module rkke_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          clear,
  input  logic          live,
  input  rkke_pkg::code_t code_in,
  output rkke_pkg::code_t code_out,
  output rkke_pkg::code_t key_bits
);
  import rkke_pkg::*;

  code_t code;
  code_t code_next;

  assign code_next = clear ? '0 : code_in;
  assign code_out  = code;
  assign key_bits  = live ? code_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      code <= '0;
    end else if (advance) begin
      code <= code_next;
    end
  end

endmodule

// ===== rtl/core/rkke_ctrl.sv =====
// Clean-run counter and base position counter of the k-mer extractor.
// Depends on rkke_pkg.
`timescale 1ns / 1ps

module rkke_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        clear,
  input  logic                        clean,
  input  logic [rkke_pkg::K_W-1:0]    k_eff,
  output rkke_pkg::ctrl_res_t         res
);
  import rkke_pkg::*;

  logic [RUN_W-1:0] clean_run;
  logic [RUN_W-1:0] clean_run_next;
  logic [IDX_W-1:0] base_index;
  logic [IDX_W-1:0] base_index_next;
  logic [RUN_W-1:0] run_base;
  logic [IDX_W-1:0] idx_base;

  assign run_base = clear ? '0 : clean_run;
  assign idx_base = clear ? '0 : base_index;

  always_comb begin
    if (!clean) begin
      clean_run_next = '0;
    end else if (run_base != RUN_MAX) begin
      clean_run_next = run_base + RUN_W'(1);
    end else begin
      clean_run_next = run_base;
    end
    base_index_next = idx_base[IDX_W-1] ? idx_base : idx_base + IDX_W'(1);
    res.emit = clean && (clean_run_next >= k_eff) && !idx_base[IDX_W-1];
    res.window_start = idx_base[POS_W-1:0] + POS_W'(1) - POS_W'(k_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clean_run  <= '0;
      base_index <= '0;
    end else if (advance) begin
      clean_run  <= clean_run_next;
      base_index <= base_index_next;
    end
  end

endmodule

// ===== rtl/core/rolling_kmer_key_extractor.sv =====
// Top level of the rolling k-mer key extractor: cell chain, counters, output stage.
// Depends on rkke_pkg, rkke_cell and rkke_ctrl.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one sequence character per beat (base_char, with
// seq_start marking the first character of a new sequence). A beat is taken at
// a rising edge with base_valid high and base_stall low. The output channel
// carries one beat per completed window (kmer_key, window_start) under
// key_valid / key_stall. Characters that do not complete a window give no beat.
// A result enters the output register as its character is taken, or the skid
// register if the output register holds a stalled beat. One character is taken
// per cycle while base_stall is low, updating the 32-cell shift chain and the
// two counters. When the receiver stalls, the output register holds its beat
// and a one-entry skid register catches the next result; base_stall rises only
// while that skid register is full. Reset clears the shift chain, the counters
// and both valid flags, and sets kmer_length to 21. kmer_length lives at byte
// address 0 of the APB port and should be written only while the block is idle.

module rolling_kmer_key_extractor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rkke_pkg::ADDR_W-1:0]   paddr,
  input  logic [rkke_pkg::DATA_W-1:0]   pwdata,
  output logic [rkke_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          base_valid,
  output logic                          base_stall,
  input  logic [rkke_pkg::CHAR_W-1:0]   base_char,
  input  logic                          seq_start,
  output logic                          key_valid,
  input  logic                          key_stall,
  output logic [rkke_pkg::KEY_W-1:0]    kmer_key,
  output logic [rkke_pkg::POS_W-1:0]    window_start
);
  import rkke_pkg::*;

  logic [K_W-1:0]    kmer_length;
  logic [K_W-1:0]    k_eff;
  logic              cfg_write;
  logic              advance;
  logic [CODE_W:0]   enc;
  code_t             chain [MAX_K+1];
  code_t             key_part [MAX_K];
  logic [KEY_W-1:0]  key_next;
  ctrl_res_t         ctrl_res;
  logic              emit_fire;
  logic              out_take;
  logic              load_out;
  logic              load_skid;
  logic              move_skid;
  logic              skid_valid;
  logic [KEY_W-1:0]  skid_key;
  logic [POS_W-1:0]  skid_start;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_KMER_LEN) ? DATA_W'(kmer_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= K_RESET;
    end else if (cfg_write && paddr == ADDR_KMER_LEN) begin
      kmer_length <= pwdata[K_W-1:0];
    end
  end

  assign k_eff      = clamp_k(kmer_length);
  assign base_stall = skid_valid;
  assign advance    = base_valid && !base_stall;
  assign enc        = encode_base(base_char);
  assign chain[0]   = enc[CODE_W-1:0];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic live;
    logic clr;
    assign live = (K_W'(i) < k_eff);
    assign clr  = (i != 0) && seq_start;
    rkke_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .clear    (clr),
      .live     (live),
      .code_in  (chain[i]),
      .code_out (chain[i+1]),
      .key_bits (key_part[i])
    );
    assign key_next[2*i +: CODE_W] = key_part[i];
  end

  rkke_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .clear   (seq_start),
    .clean   (enc[CODE_W]),
    .k_eff   (k_eff),
    .res     (ctrl_res)
  );

  assign emit_fire = advance && ctrl_res.emit;
  assign out_take  = key_valid && !key_stall;
  assign load_skid = emit_fire && key_valid && !out_take;
  assign load_out  = emit_fire && !(key_valid && !out_take);
  assign move_skid = !emit_fire && out_take && skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      key_valid  <= load_out || move_skid || (key_valid && !out_take);
      skid_valid <= load_skid || (skid_valid && !move_skid);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kmer_key     <= key_next;
      window_start <= ctrl_res.window_start;
    end else if (move_skid) begin
      kmer_key     <= skid_key;
      window_start <= skid_start;
    end
    if (load_skid) begin
      skid_key   <= key_next;
      skid_start <= ctrl_res.window_start;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> key_valid)
    else $error("skid register full while output register is empty");

  a_key_masked : assert property (@(posedge clk) disable iff (rst)
    key_valid |-> ((kmer_key >> {k_eff, 1'b0}) == '0))
    else $error("key has bits set above the window length");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !key_stall) |=> (key_valid && !skid_valid))
    else $error("skid beat not moved to the output register");

endmodule
